@@ rtl/core/sorted_priority_insert_queue_unit_assert.svh @@
// Assertion macros for the sorted priority queue.
// Each macro checks on the rising edge of clk and is off while rst_n is low.
`ifndef SORTED_PRIORITY_INSERT_QUEUE_UNIT_ASSERT_SVH
`define SORTED_PRIORITY_INSERT_QUEUE_UNIT_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication.
`define SPIQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spiq assertion failed");
// Next-cycle implication.
`define SPIQ_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spiq assertion failed");
`else
`define SPIQ_ASSERT_IMP(lbl, ante, cons)
`define SPIQ_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ rtl/core/spiq_pkg.sv @@
package spiq_pkg;

    localparam int DW = 32;

    // Input operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DUMP   = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_DROPPED  = 2'd1;
    localparam logic [1:0] ST_DUMPED   = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    // One stored entry as seen by a neighbor cell
    typedef struct packed {
        logic                 valid;
        logic signed [DW-1:0] data;
        logic signed [DW-1:0] prio;
    } spiq_entry_t;

    // Broadcast control from the controller to every cell
    typedef struct packed {
        logic                 ins;
        logic                 rot;
        logic signed [DW-1:0] data;
        logic signed [DW-1:0] prio;
    } spiq_ctrl_t;

endpackage

@@ rtl/core/spiq_cell.sv @@
module spiq_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  spiq_pkg::spiq_ctrl_t  ctrl,
    input  spiq_pkg::spiq_entry_t prev_entry,
    input  logic               prev_take,
    input  spiq_pkg::spiq_entry_t next_entry,
    input  spiq_pkg::spiq_entry_t head_entry,
    output spiq_pkg::spiq_entry_t entry,
    output logic               take
);
    import spiq_pkg::*;

    logic                 valid_reg;
    logic                 valid_next;
    logic signed [DW-1:0] data_reg;
    logic signed [DW-1:0] data_next;
    logic signed [DW-1:0] prio_reg;
    logic signed [DW-1:0] prio_next;

    // Claim the slot when empty or holding a priority not below the new one
    assign take = !valid_reg || (prio_reg >= ctrl.prio);

    assign entry.valid = valid_reg;
    assign entry.data  = data_reg;
    assign entry.prio  = prio_reg;

    // Pick the next contents: insert, shift right, rotate left, or hold
    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        prio_next  = prio_reg;
        if (ctrl.ins && take)
        begin
            if (prev_take)
            begin
                valid_next = prev_entry.valid;
                data_next  = prev_entry.data;
                prio_next  = prev_entry.prio;
            end
            else
            begin
                valid_next = 1'b1;
                data_next  = ctrl.data;
                prio_next  = ctrl.prio;
            end
        end
        else if (ctrl.rot && valid_reg)
        begin
            if (next_entry.valid)
            begin
                data_next = next_entry.data;
                prio_next = next_entry.prio;
            end
            else
            begin
                data_next = head_entry.data;
                prio_next = head_entry.prio;
            end
        end
    end

    // Register the valid bit, cleared under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        prio_reg <= prio_next;
    end

endmodule

@@ rtl/core/sorted_priority_insert_queue_unit.sv @@
// Insert: one result, registered in the cycle after the transfer; one insert per
// cycle while out_ready stays high. Dump of N stored entries: N results, the first
// registered in the cycle after the transfer, then one per cycle while out_ready stays
// high; input is held off until the last result is loaded. Dump of an empty store: one
// result, registered in the cycle after the transfer. rst_n (asynchronous, active low)
// empties the store and the output register; entry payloads are not cleared.
module sorted_priority_insert_queue_unit #(
    parameter int CAPACITY = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            op,
    input  logic signed [spiq_pkg::DW-1:0]  item_data,
    input  logic signed [spiq_pkg::DW-1:0]  item_priority,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [1:0]                      status,
    output logic signed [spiq_pkg::DW-1:0]  out_data,
    output logic signed [spiq_pkg::DW-1:0]  out_priority,
    output logic                            last
);
    import spiq_pkg::*;

    `include "sorted_priority_insert_queue_unit_assert.svh"

    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } state_t;

    state_t               state_reg;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        rem_reg;
    logic                 out_valid_reg;
    logic [1:0]           status_reg;
    logic signed [DW-1:0] out_data_reg;
    logic signed [DW-1:0] out_priority_reg;
    logic                 last_reg;

    logic                 out_free;
    logic                 accept;
    logic                 full;
    logic                 empty;
    spiq_ctrl_t           ctrl;

    spiq_entry_t          cell_entry [CAPACITY];
    spiq_entry_t          prev_e     [CAPACITY];
    spiq_entry_t          next_e     [CAPACITY];
    logic                 cell_take  [CAPACITY];
    logic                 prev_t     [CAPACITY];
    logic [CAPACITY-1:0]  valid_vec;

    // Handshake
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign accept   = in_valid && in_ready;
    assign full     = (count_reg == CW'(CAPACITY));
    assign empty    = (count_reg == '0);

    // Broadcast control to the cell row
    assign ctrl.ins  = accept && (op == OP_INSERT) && !full;
    assign ctrl.rot  = (state_reg == S_DUMP && out_free)
                     || (accept && (op == OP_DUMP) && !empty);
    assign ctrl.data = item_data;
    assign ctrl.prio = item_priority;

    // Build the cell row with neighbor links
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign prev_e[i] = '0;
            assign prev_t[i] = 1'b0;
        end
        else
        begin : g_body
            assign prev_e[i] = cell_entry[i-1];
            assign prev_t[i] = cell_take[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign next_e[i] = '0;
        end
        else
        begin : g_mid
            assign next_e[i] = cell_entry[i+1];
        end

        assign valid_vec[i] = cell_entry[i].valid;

        spiq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .prev_entry (prev_e[i]),
            .prev_take  (prev_t[i]),
            .next_entry (next_e[i]),
            .head_entry (cell_entry[0]),
            .entry      (cell_entry[i]),
            .take       (cell_take[i])
        );
    end

    // Sequence inserts and dumps, load the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            rem_reg          <= '0;
            out_valid_reg    <= 1'b0;
            status_reg       <= ST_INSERTED;
            out_data_reg     <= '0;
            out_priority_reg <= '0;
            last_reg         <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        out_valid_reg    <= 1'b1;
                        out_data_reg     <= '0;
                        out_priority_reg <= '0;
                        last_reg         <= 1'b1;
                        if (op == OP_INSERT)
                        begin
                            if (full)
                            begin
                                status_reg <= ST_DROPPED;
                            end
                            else
                            begin
                                status_reg <= ST_INSERTED;
                                count_reg  <= count_reg + CW'(1);
                            end
                        end
                        else if (empty)
                        begin
                            status_reg <= ST_EMPTY;
                        end
                        else
                        begin
                            // Emit the head now and rotate the row
                            status_reg       <= ST_DUMPED;
                            out_data_reg     <= cell_entry[0].data;
                            out_priority_reg <= cell_entry[0].prio;
                            last_reg         <= (count_reg == CW'(1));
                            rem_reg          <= count_reg - CW'(1);
                            if (count_reg != CW'(1))
                            begin
                                state_reg <= S_DUMP;
                            end
                        end
                    end
                    else if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                end
                S_DUMP:
                begin
                    if (out_free)
                    begin
                        out_valid_reg    <= 1'b1;
                        status_reg       <= ST_DUMPED;
                        out_data_reg     <= cell_entry[0].data;
                        out_priority_reg <= cell_entry[0].prio;
                        last_reg         <= (rem_reg == CW'(1));
                        rem_reg          <= rem_reg - CW'(1);
                        if (rem_reg == CW'(1))
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign out_data     = out_data_reg;
    assign out_priority = out_priority_reg;
    assign last         = last_reg;

    // Checks
    `SPIQ_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CW'(CAPACITY))
    `SPIQ_ASSERT_IMP(a_valid_matches_count, 1'b1, $countones(valid_vec) == count_reg)
    `SPIQ_ASSERT_IMP(a_dump_rem_nonzero, state_reg == S_DUMP, rem_reg != '0)
    `SPIQ_ASSERT_NXT(a_insert_grows, ctrl.ins, count_reg == $past(count_reg) + CW'(1))

endmodule

@@ dv/sorted_priority_insert_queue_unit_checker.sv @@
module sorted_priority_insert_queue_unit_checker #(
    parameter int CAPACITY = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic                            op,
    input  logic signed [spiq_pkg::DW-1:0]  item_data,
    input  logic signed [spiq_pkg::DW-1:0]  item_priority,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [1:0]                      status,
    input  logic signed [spiq_pkg::DW-1:0]  out_data,
    input  logic signed [spiq_pkg::DW-1:0]  out_priority,
    input  logic                            last,
    output int                              errors,
    output int                              outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]                     status;
        logic signed [spiq_pkg::DW-1:0] data;
        logic signed [spiq_pkg::DW-1:0] prio;
        logic                           last;
    } queue_result_t;

    // Shadow copy of the sorted store, head at index 0
    logic signed [spiq_pkg::DW-1:0] shadow_data [CAPACITY];
    logic signed [spiq_pkg::DW-1:0] shadow_prio [CAPACITY];
    int                             shadow_count = 0;
    queue_result_t                  predicted_results [$];
    int                             mismatch_count = 0;

    // Update the shadow store and queue up the results one transfer causes
    function automatic void apply_queue_item(input logic op_i,
                                             input logic signed [spiq_pkg::DW-1:0] data_i,
                                             input logic signed [spiq_pkg::DW-1:0] prio_i);
        int            slot;
        int            k;
        queue_result_t r;
        r = '{spiq_pkg::ST_INSERTED, '0, '0, 1'b1};
        if (op_i == spiq_pkg::OP_INSERT) begin
            if (shadow_count >= CAPACITY) begin
                r.status = spiq_pkg::ST_DROPPED;
            end else begin
                // new entry goes ahead of every entry with priority >= its own
                slot = 0;
                while (slot < shadow_count && shadow_prio[slot] < prio_i)
                    slot++;
                for (k = shadow_count; k > slot; k--) begin
                    shadow_data[k] = shadow_data[k-1];
                    shadow_prio[k] = shadow_prio[k-1];
                end
                shadow_data[slot] = data_i;
                shadow_prio[slot] = prio_i;
                shadow_count++;
            end
            predicted_results.push_back(r);
        end else if (shadow_count == 0) begin
            r.status = spiq_pkg::ST_EMPTY;
            predicted_results.push_back(r);
        end else begin
            for (k = 0; k < shadow_count; k++) begin
                r.status = spiq_pkg::ST_DUMPED;
                r.data   = shadow_data[k];
                r.prio   = shadow_prio[k];
                r.last   = (k == shadow_count - 1);
                predicted_results.push_back(r);
            end
        end
    endfunction

    function automatic void compare_field(input string name,
                                          input logic signed [spiq_pkg::DW-1:0] want,
                                          input logic signed [spiq_pkg::DW-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Check output transfers first: a result never belongs to an input of the same edge
    always @(posedge clk) begin
        queue_result_t want;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (predicted_results.size() == 0) begin
                    $error("status: expected no result, actual %0d", status);
                    mismatch_count++;
                end else begin
                    want = predicted_results.pop_front();
                    compare_field("status", want.status, status);
                    compare_field("out_data", want.data, out_data);
                    compare_field("out_priority", want.prio, out_priority);
                    compare_field("last", want.last, last);
                end
            end
            if (in_valid && in_ready)
                apply_queue_item(op, item_data, item_priority);
        end
        errors      <= mismatch_count;
        outstanding <= predicted_results.size();
    end

endmodule

@@ dv/sorted_priority_insert_queue_unit_test.sv @@
module sorted_priority_insert_queue_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY     = 16;
    localparam int RANDOM_ITEMS = 140;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 10;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_ready;
    logic                            op;
    logic signed [spiq_pkg::DW-1:0]  item_data;
    logic signed [spiq_pkg::DW-1:0]  item_priority;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [1:0]                      status;
    logic signed [spiq_pkg::DW-1:0]  out_data;
    logic signed [spiq_pkg::DW-1:0]  out_priority;
    logic                            last;

    int checker_errors;
    int results_owed;
    int send_idle    = 32;
    int recv_idle    = 76;
    int items_sent   = 0;
    int quiet_cycles = 0;

    sorted_priority_insert_queue_unit #(
        .CAPACITY(CAPACITY)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .item_data    (item_data),
        .item_priority(item_priority),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .out_data     (out_data),
        .out_priority (out_priority),
        .last         (last)
    );

    sorted_priority_insert_queue_unit_checker #(
        .CAPACITY(CAPACITY)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .item_data    (item_data),
        .item_priority(item_priority),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .out_data     (out_data),
        .out_priority (out_priority),
        .last         (last),
        .errors       (checker_errors),
        .outstanding  (results_owed)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Receiver backpressure
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle);
    end

    // End the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Present one item, idling first at the current rate, and hold it until the transfer
    task automatic send_item(input logic op_i,
                             input logic [spiq_pkg::DW-1:0] data_i,
                             input logic [spiq_pkg::DW-1:0] prio_i);
        if (items_sent < 60) begin
            send_idle = 32;
            recv_idle = 76;
        end else if (items_sent < 120) begin
            send_idle = 76;
            recv_idle = 32;
        end else begin
            send_idle = 0;
            recv_idle = 0;
        end
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        op            <= op_i;
        item_data     <= data_i;
        item_priority <= prio_i;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        op            <= spiq_pkg::OP_INSERT;
        item_data     <= '0;
        item_priority <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Dump of an empty store
        send_item(spiq_pkg::OP_DUMP, 32'h0000_0000, 32'h0000_0000);

        // Head, tail, middle and tie placements, with extreme data and priorities
        send_item(spiq_pkg::OP_INSERT, 32'h7fff_ffff, 32'd0);
        send_item(spiq_pkg::OP_INSERT, 32'h8000_0000, 32'd100);
        send_item(spiq_pkg::OP_INSERT, 32'h0000_0000, -32'sd100);
        send_item(spiq_pkg::OP_INSERT, 32'hffff_ffff, 32'd50);
        send_item(spiq_pkg::OP_INSERT, 32'd11, 32'd50);
        send_item(spiq_pkg::OP_INSERT, 32'd12, 32'h7fff_ffff);
        send_item(spiq_pkg::OP_INSERT, 32'd13, 32'h8000_0000);
        send_item(spiq_pkg::OP_INSERT, 32'd14, 32'hffff_ffff);
        send_item(spiq_pkg::OP_INSERT, 32'd15, 32'd1);
        send_item(spiq_pkg::OP_INSERT, 32'd16, 32'd100);
        send_item(spiq_pkg::OP_INSERT, 32'd17, 32'h7fff_ffff);
        send_item(spiq_pkg::OP_INSERT, 32'd18, 32'h8000_0000);

        // Dump of a partly filled store, ignored fields all ones
        send_item(spiq_pkg::OP_DUMP, 32'hffff_ffff, 32'hffff_ffff);

        // Fill the store, then drop an insert on a full store and dump it
        repeat (CAPACITY - 12)
            send_item(spiq_pkg::OP_INSERT, $urandom, $urandom);
        send_item(spiq_pkg::OP_INSERT, $urandom, $urandom);
        send_item(spiq_pkg::OP_DUMP, $urandom, $urandom);

        // Random mix of dumps and inserts with random content
        repeat (RANDOM_ITEMS) begin
            if ($urandom_range(99) < 30)
                send_item(spiq_pkg::OP_DUMP, $urandom, $urandom);
            else
                send_item(spiq_pkg::OP_INSERT, $urandom, $urandom);
        end
        in_valid <= 1'b0;

        // Drain outstanding results, then let the output settle
        do
            @(posedge clk);
        while (results_owed != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (checker_errors == 0 && results_owed == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/spiq_pkg.sv
rtl/core/spiq_cell.sv
rtl/core/sorted_priority_insert_queue_unit.sv
dv/sorted_priority_insert_queue_unit_checker.sv
dv/sorted_priority_insert_queue_unit_test.sv
